>>> hdl/u8tt_pkg.sv
// shared types and constants for the tick-driven 8n1 uart transceiver
package u8tt_pkg;

    localparam int unsigned BitTicksW = 16;
    localparam int unsigned RxWaitW   = 17;
    localparam int unsigned TxCountW  = 4;

    localparam logic [BitTicksW-1:0] BitTicksReset = 16'd52;
    localparam logic [TxCountW-1:0]  TxFrameBits   = 4'd10;
    localparam logic [TxCountW-1:0]  TxStartCount  = 4'd9;

    typedef struct packed {
        logic       rx_line;
        logic       send_valid;
        logic [7:0] send_byte;
        logic       take_byte;
    } in_item_t;

    typedef struct packed {
        logic       tx_line;
        logic       tx_busy;
        logic       rx_ready;
        logic [7:0] rx_byte;
    } out_item_t;

    // per-tick control from the top level to both engines
    typedef struct packed {
        logic                 step;
        logic [BitTicksW-1:0] bit_ticks;
    } tick_ctrl_t;

    // one bit time minus one, a zero setting counts as one tick
    function automatic logic [BitTicksW-1:0] bit_reload(input logic [BitTicksW-1:0] bt);
        logic [BitTicksW-1:0] r;
        r = (bt == '0) ? '0 : bt - 1'b1;
        return r;
    endfunction

endpackage

>>> hdl/u8tt_channels.sv
// handshake channel interfaces for items, results and configuration writes
interface u8tt_in_if
    import u8tt_pkg::*;
();
    logic     valid;
    logic     ready;
    in_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface u8tt_out_if
    import u8tt_pkg::*;
();
    logic      valid;
    logic      ready;
    out_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface u8tt_cfg_if
    import u8tt_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [BitTicksW-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> hdl/u8tt_tx.sv
// transmit engine: bit-time tick, frame counter and shift register
module u8tt_tx
    import u8tt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  tick_ctrl_t ctrl,
    input  logic       send_valid,
    input  logic [7:0] send_byte,
    output logic       tx_line,
    output logic       tx_busy
);

    logic [BitTicksW-1:0] wait_reg, wait_next;
    logic [TxCountW-1:0]  bits_reg, bits_next;
    logic [7:0]           shift_reg, shift_next;
    logic                 level_reg, level_next;

    always_comb
    begin
        wait_next  = wait_reg;
        bits_next  = bits_reg;
        shift_next = shift_reg;
        level_next = level_reg;
        if (wait_reg != '0)
        begin
            wait_next = wait_reg - 1'b1;
        end
        else
        begin
            wait_next = bit_reload(ctrl.bit_ticks);
            if (bits_reg != '0)
            begin
                bits_next = bits_reg - 1'b1;
                if (bits_next == TxStartCount)
                begin
                    level_next = 1'b0;
                end
                else
                begin
                    // stop bit comes from the ones shifted in
                    level_next = shift_reg[0];
                    shift_next = {1'b1, shift_reg[7:1]};
                end
            end
        end
        if (send_valid && bits_next == '0)
        begin
            shift_next = send_byte;
            bits_next  = TxFrameBits;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wait_reg  <= '0;
            bits_reg  <= '0;
            shift_reg <= '0;
            level_reg <= 1'b1;
        end
        else if (ctrl.step)
        begin
            wait_reg  <= wait_next;
            bits_reg  <= bits_next;
            shift_reg <= shift_next;
            level_reg <= level_next;
        end
    end

    assign tx_line = level_reg;
    assign tx_busy = (bits_reg != '0);

endmodule

>>> hdl/u8tt_rx.sv
// receive engine: start detect, mid-bit sampling and byte holding register
module u8tt_rx
    import u8tt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  tick_ctrl_t ctrl,
    input  logic       rx_line,
    input  logic       take_byte,
    output logic       rx_ready,
    output logic [7:0] rx_byte
);

    logic               active_reg, active_next;
    logic [RxWaitW-1:0] wait_reg, wait_next;
    logic [7:0]         mask_reg, mask_next;
    logic [7:0]         shift_reg, shift_next;
    logic [7:0]         held_reg, held_next;
    logic               done_reg, done_next;
    logic [RxWaitW-1:0] eff_bit;
    logic [RxWaitW-1:0] start_wait;

    always_comb
    begin
        eff_bit    = (ctrl.bit_ticks == '0) ? RxWaitW'(1) : RxWaitW'(ctrl.bit_ticks);
        // one and a half bit times to the middle of the first data bit
        start_wait = eff_bit + (eff_bit >> 1) - 1'b1;

        active_next = active_reg;
        wait_next   = wait_reg;
        mask_next   = mask_reg;
        shift_next  = shift_reg;
        held_next   = held_reg;
        done_next   = take_byte ? 1'b0 : done_reg;

        if (!active_reg)
        begin
            if (!rx_line)
            begin
                active_next = 1'b1;
                wait_next   = start_wait;
                shift_next  = '0;
                mask_next   = 8'd1;
            end
        end
        else if (wait_reg != '0)
        begin
            wait_next = wait_reg - 1'b1;
        end
        else if (mask_reg != '0)
        begin
            if (rx_line)
            begin
                shift_next = shift_reg | mask_reg;
            end
            mask_next = {mask_reg[6:0], 1'b0};
            wait_next = RxWaitW'(bit_reload(ctrl.bit_ticks));
        end
        else
        begin
            held_next   = shift_reg;
            done_next   = 1'b1;
            active_next = 1'b0;
            wait_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            wait_reg   <= '0;
            mask_reg   <= '0;
            shift_reg  <= '0;
            held_reg   <= '0;
            done_reg   <= 1'b0;
        end
        else if (ctrl.step)
        begin
            active_reg <= active_next;
            wait_reg   <= wait_next;
            mask_reg   <= mask_next;
            shift_reg  <= shift_next;
            held_reg   <= held_next;
            done_reg   <= done_next;
        end
    end

    assign rx_ready = done_reg;
    assign rx_byte  = held_reg;

endmodule

>>> hdl/uart_8n1_tick_transceiver_unit.sv
// top level of the tick-driven 8n1 uart transceiver
// usage:
//   in_ch carries one item per timer tick: the sampled receive line, an
//   optional byte to send and an optional acknowledge of the received byte
//   out_ch returns one item per input item: transmit line level, busy flag,
//   ready flag and the last received byte, all as they stand after the tick
//   cfg writes bit_ticks, the number of ticks per bit (zero acts as one);
//   write it only while no tick is in flight, frames already running keep
//   their current counts and pick up the new value at the next reload
// latency and throughput:
//   the result of an item appears on out_ch the cycle after it is accepted;
//   one item per cycle is sustained while out_ch.ready is high; the engine
//   state registers double as the result register, nothing else limits the rate
// stall behavior:
//   while a result waits and out_ch.ready is low, in_ch.ready drops and the
//   engines hold; a result taken in the same cycle frees room for the next
// reset:
//   rst_n clears both engines, sets the transmit line idle high and loads
//   bit_ticks with 52; the first tick after reset fires a transmit bit time
module uart_8n1_tick_transceiver_unit
    import u8tt_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    u8tt_in_if.sink     in_ch,
    u8tt_out_if.source  out_ch,
    u8tt_cfg_if.sink    cfg
);

    logic [BitTicksW-1:0] bit_ticks_reg;
    logic                 out_valid_reg;
    logic                 accept;
    tick_ctrl_t           ctrl;

    // configuration register, always writable
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_ticks_reg <= BitTicksReset;
        end
        else if (cfg.valid)
        begin
            bit_ticks_reg <= cfg.data;
        end
    end

    // take a tick whenever the result slot is empty or being emptied
    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign accept      = in_ch.valid && in_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            out_valid_reg <= in_ch.valid;
        end
    end

    assign ctrl.step      = accept;
    assign ctrl.bit_ticks = bit_ticks_reg;

    // transmit side
    u8tt_tx u_tx (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .send_valid (in_ch.data.send_valid),
        .send_byte  (in_ch.data.send_byte),
        .tx_line    (out_ch.data.tx_line),
        .tx_busy    (out_ch.data.tx_busy)
    );

    // receive side
    u8tt_rx u_rx (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .rx_line    (in_ch.data.rx_line),
        .take_byte  (in_ch.data.take_byte),
        .rx_ready   (out_ch.data.rx_ready),
        .rx_byte    (out_ch.data.rx_byte)
    );

    assign out_ch.valid = out_valid_reg;

endmodule
